// ----- hw/rtl/hbcd_pkg.sv -----
// ----------------------------------------------------------------------------
// hbcd_pkg
// Shared types, codes and helpers for the HTTP body chunked decoder.
// ----------------------------------------------------------------------------
package hbcd_pkg;

  // decoder phase for chunked transfer encoding
  typedef enum logic [2:0] {
    PH_SIZE_START  = 3'd0,
    PH_SIZE_DIGITS = 3'd1,
    PH_SIZE_LF     = 3'd2,
    PH_DATA        = 3'd3,
    PH_TAIL_CR     = 3'd4,
    PH_TAIL_LF     = 3'd5
  } phase_t;

  // body modes
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_FIXED   = 2'd1;
  localparam logic [1:0] MODE_CHUNKED = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // configuration register indexes
  localparam logic CFG_IDX_BODY_MODE = 1'b0;
  localparam logic CFG_IDX_FIXED_LEN = 1'b1;

  // field widths
  localparam int FIXED_LEN_W = 32;
  localparam int MODE_W      = 2;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // one input transaction
  typedef struct packed {
    logic       start_message;
    logic [7:0] data_byte;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [1:0] status;
    logic       payload_valid;
    logic [7:0] payload_byte;
  } result_t;

  // hex digit decode
  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b0;
    h.digit = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      h.ok    = 1'b1;
      h.digit = c[3:0];
    end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
      // low nibble of 'a'..'f' and 'A'..'F' runs 1..6
      h.ok    = 1'b1;
      h.digit = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

// ----- hw/rtl/hbcd_in_reg.sv -----
// ----------------------------------------------------------------------------
// hbcd_in_reg
// Input register stage: captures one byte transaction for the decode stage.
// ----------------------------------------------------------------------------
module hbcd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hbcd_pkg::item_t   in_item,
  output logic              s1_valid,
  input  logic              s1_take,
  output hbcd_pkg::item_t   s1_item
);

  logic            valid_r;
  hbcd_pkg::item_t item_r;

  // stage is free when empty or being drained this cycle
  assign in_ready = !valid_r || s1_take;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hw/rtl/hbcd_core.sv -----
// ----------------------------------------------------------------------------
// hbcd_core
// Decoder state and per-byte update for no-body, fixed and chunked modes.
// ----------------------------------------------------------------------------
module hbcd_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  hbcd_pkg::item_t                      item,
  input  logic [hbcd_pkg::MODE_W-1:0]          body_mode,
  input  logic [hbcd_pkg::FIXED_LEN_W-1:0]     fixed_length,
  output hbcd_pkg::result_t                    result
);

  // counter holds either a chunk size or the fixed-length byte count
  localparam int CNT_W = (SIZE_BITS > hbcd_pkg::FIXED_LEN_W) ? SIZE_BITS
                                                             : hbcd_pkg::FIXED_LEN_W;

  hbcd_pkg::phase_t       phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]   accum_r, accum_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic                   last_r, last_nxt;
  logic                   err_r, err_nxt;
  logic                   cmp_r, cmp_nxt;

  hbcd_pkg::hex_t         hex;
  logic [CNT_W-1:0]       len_ext;
  logic                   valid;
  logic [7:0]             c;

  // per-byte decode
  always_comb begin
    c       = item.data_byte;
    hex     = hbcd_pkg::hex_decode(c);
    len_ext = CNT_W'(fixed_length);
    valid   = 1'b0;

    // start of message clears the state before the byte is handled
    if (item.start_message) begin
      phase_nxt = hbcd_pkg::PH_SIZE_START;
      accum_nxt = '0;
      rem_nxt   = '0;
      last_nxt  = 1'b0;
      err_nxt   = 1'b0;
      cmp_nxt   = 1'b0;
    end else begin
      phase_nxt = phase_r;
      accum_nxt = accum_r;
      rem_nxt   = rem_r;
      last_nxt  = last_r;
      err_nxt   = err_r;
      cmp_nxt   = cmp_r;
    end

    if (!err_nxt && !cmp_nxt) begin
      case (body_mode)
        hbcd_pkg::MODE_FIXED: begin
          if (rem_nxt > len_ext) begin
            err_nxt = 1'b1;
          end else if (rem_nxt == len_ext) begin
            cmp_nxt = 1'b1;
          end else begin
            if (rem_nxt + CNT_W'(1) == len_ext) begin
              cmp_nxt = 1'b1;
            end
            rem_nxt = rem_nxt + CNT_W'(1);
            valid   = 1'b1;
          end
        end
        hbcd_pkg::MODE_CHUNKED: begin
          unique case (phase_nxt)
            hbcd_pkg::PH_SIZE_DIGITS: begin
              if (hex.ok) begin
                // top nibble must be clear before another digit shifts in
                if (accum_nxt[SIZE_BITS-1 -: 4] != 4'd0) begin
                  err_nxt = 1'b1;
                end else begin
                  accum_nxt = {accum_nxt[SIZE_BITS-5:0], hex.digit};
                end
              end else if (c == hbcd_pkg::CH_CR) begin
                phase_nxt = hbcd_pkg::PH_SIZE_LF;
              end else begin
                err_nxt = 1'b1;
              end
            end
            hbcd_pkg::PH_SIZE_LF: begin
              if (c != hbcd_pkg::CH_LF) begin
                err_nxt = 1'b1;
              end else if (accum_nxt == '0) begin
                last_nxt  = 1'b1;
                phase_nxt = hbcd_pkg::PH_TAIL_CR;
              end else begin
                rem_nxt   = CNT_W'(accum_nxt);
                phase_nxt = hbcd_pkg::PH_DATA;
              end
            end
            hbcd_pkg::PH_DATA: begin
              valid = 1'b1;
              if (rem_nxt <= CNT_W'(1)) begin
                rem_nxt   = '0;
                phase_nxt = hbcd_pkg::PH_TAIL_CR;
              end else begin
                rem_nxt = rem_nxt - CNT_W'(1);
              end
            end
            hbcd_pkg::PH_TAIL_CR: begin
              if (c == hbcd_pkg::CH_CR) begin
                phase_nxt = hbcd_pkg::PH_TAIL_LF;
              end else begin
                err_nxt = 1'b1;
              end
            end
            hbcd_pkg::PH_TAIL_LF: begin
              if (c != hbcd_pkg::CH_LF) begin
                err_nxt = 1'b1;
              end else if (last_nxt) begin
                cmp_nxt = 1'b1;
              end else begin
                accum_nxt = '0;
                phase_nxt = hbcd_pkg::PH_SIZE_START;
              end
            end
            default: begin
              // size line start, and any code outside the phase list
              if (hex.ok) begin
                accum_nxt = SIZE_BITS'(hex.digit);
                phase_nxt = hbcd_pkg::PH_SIZE_DIGITS;
              end else begin
                err_nxt = 1'b1;
              end
            end
          endcase
        end
        default: begin
          // no body, and the unused mode code
          cmp_nxt = 1'b1;
        end
      endcase
    end

    // error wins over payload and completion
    result.payload_valid = valid && !err_nxt;
    result.payload_byte  = (valid && !err_nxt) ? c : 8'd0;
    if (err_nxt) begin
      result.status = hbcd_pkg::STATUS_ERROR;
    end else if (cmp_nxt) begin
      result.status = hbcd_pkg::STATUS_DONE;
    end else begin
      result.status = hbcd_pkg::STATUS_BUSY;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hbcd_pkg::PH_SIZE_START;
      accum_r <= '0;
      rem_r   <= '0;
      last_r  <= 1'b0;
      err_r   <= 1'b0;
      cmp_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      rem_r   <= rem_nxt;
      last_r  <= last_nxt;
      err_r   <= err_nxt;
      cmp_r   <= cmp_nxt;
    end
  end

endmodule

// ----- hw/rtl/hbcd_out_reg.sv -----
// ----------------------------------------------------------------------------
// hbcd_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module hbcd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  hbcd_pkg::result_t  load_result,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output hbcd_pkg::result_t  out_result
);

  logic              valid_r;
  hbcd_pkg::result_t result_r;

  // free when empty or emptied in this cycle
  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= load_result;
    end
  end

endmodule

// ----- hw/rtl/http_body_chunked_decoder_top.sv -----
// ----------------------------------------------------------------------------
// http_body_chunked_decoder_top
// HTTP message body decoder: no body, fixed content length or chunked.
// ----------------------------------------------------------------------------
//
//  channel | direction | transaction
//  --------+-----------+-----------------------------------------------------
//  in_     | sink      | one body byte, optional start-of-message flag
//  out_    | source    | one result per byte: payload byte, flag, status
//  cfg_    | write     | body_mode (index 0), fixed_length (index 1)
//
//  one byte per cycle sustained while out_ is ready; a taken byte passes
//  the input register, then the decode into the result register
//  throughput is set by the per-byte state update in hbcd_core
//  rst_n is synchronous, active low; state resets to zero, no body mode
//  a stalled out_ channel holds its result and backs up the input stage
//
module http_body_chunked_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] start_message
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] payload_byte
  output logic [2:0]  out_tuser,  // [0] payload_valid, [2:1] status
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [hbcd_pkg::MODE_W-1:0]      body_mode_r;
  logic [hbcd_pkg::FIXED_LEN_W-1:0] fixed_length_r;

  hbcd_pkg::item_t   in_item;
  hbcd_pkg::item_t   s1_item;
  hbcd_pkg::result_t core_result;
  hbcd_pkg::result_t out_result;
  logic              s1_valid;
  logic              can_load;
  logic              fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mode_r    <= hbcd_pkg::MODE_NONE;
      fixed_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hbcd_pkg::CFG_IDX_BODY_MODE: body_mode_r    <= cfg_wdata[hbcd_pkg::MODE_W-1:0];
        hbcd_pkg::CFG_IDX_FIXED_LEN: fixed_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_item.data_byte     = in_tdata;
  assign in_item.start_message = in_tuser;

  // decode fires when a byte waits and the result register has room
  assign fire = s1_valid && can_load;

  hbcd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_take  (can_load),
    .s1_item  (s1_item)
  );

  hbcd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (s1_item),
    .body_mode    (body_mode_r),
    .fixed_length (fixed_length_r),
    .result       (core_result)
  );

  hbcd_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (fire),
    .load_result (core_result),
    .can_load    (can_load),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_result  (out_result)
  );

  assign out_tdata    = out_result.payload_byte;
  assign out_tuser[0] = out_result.payload_valid;
  assign out_tuser[2:1] = out_result.status;

endmodule

// ----- hw/rtl/hbcd_checker.sv -----
// ----------------------------------------------------------------------------
// hbcd_checker
// Port-level checks for the HTTP body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hbcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a non-payload result carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'd0)
    else $error("non-payload result with nonzero byte");

  // payload is never passed with an error status
  a_no_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] != hbcd_pkg::STATUS_ERROR)
    else $error("payload flagged in error state");

endmodule

bind http_body_chunked_decoder_top hbcd_checker u_hbcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
